// ----- design/bba_pkg.sv -----
package bba_pkg;

  // Field widths of the request and result beats.
  localparam int ACT_W       = 2;
  localparam int BLOCK_W     = 15;
  localparam int CFG_W       = 4;
  localparam int BYTE_ADDR_W = BLOCK_W - 3;

  // Map geometry defaults and fixed limits.
  localparam int MAP_BYTES_DEF    = 4096;
  localparam int SECTOR_BYTES_DEF = 512;
  localparam int MAX_MAP_BYTES    = (1 << BLOCK_W) / 8;
  localparam int CFG_RESET        = 6;

  // One memory row holds sixteen map bytes.
  localparam int ROW_BYTES = 16;
  localparam int ROW_BITS  = ROW_BYTES * 8;
  localparam int ROW_SHIFT = 4;
  localparam int BIT_W     = 7;

  localparam logic [7:0] FULL_BYTE = 8'hFF;

  typedef enum logic [ACT_W-1:0] {
    ACT_TEST    = 2'd0,
    ACT_FIND    = 2'd1,
    ACT_ASSIGN  = 2'd2,
    ACT_RELEASE = 2'd3
  } act_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;
    logic start;
    logic scan;
    logic pick;
    logic resp;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic is_find;
    logic map_empty;
    logic hit;
    logic last_row;
  } sts_t;

endpackage

// ----- design/bba_in_if.sv -----
interface bba_in_if;
  import bba_pkg::*;

  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [BLOCK_W-1:0] block;

  modport source (output valid, output action, output block, input ready);
  modport sink   (input valid, input action, input block, output ready);
endinterface

// ----- design/bba_out_if.sv -----
interface bba_out_if;
  import bba_pkg::*;

  logic               valid;
  logic               ready;
  logic               is_free;
  logic [BLOCK_W-1:0] free_block;
  logic               found;
  logic               out_of_range;

  modport source (output valid, output is_free, output free_block, output found,
                  output out_of_range, input ready);
  modport sink   (input valid, input is_free, input free_block, input found,
                  input out_of_range, output ready);
endinterface

// ----- design/block_bitmap_allocator_core.sv -----
// Test, assign and release: the request passes the look and result states and
// the result beat is raised once the result register is free. Find: the row
// memory is read one 16-byte map row a cycle until a row with a free byte or
// the last valid row is read. One request is in flight at a time.
// After reset a clearing pass writes every map row; no request is taken
// meanwhile, configuration writes are taken as ever.
module block_bitmap_allocator_core #(
  parameter int MAP_BYTES    = bba_pkg::MAP_BYTES_DEF,
  parameter int SECTOR_BYTES = bba_pkg::SECTOR_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  bba_in_if.sink                    in_ch,
  bba_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [bba_pkg::CFG_W-1:0] cfg_wdata
);
  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of requests.
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Bitmap storage, search and result register.
  bba_dp #(
    .MAP_BYTES    (MAP_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_ch.action),
    .in_block         (in_ch.block),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_is_free      (out_ch.is_free),
    .out_free_block   (out_ch.free_block),
    .out_found        (out_ch.found),
    .out_out_of_range (out_ch.out_of_range)
  );

  // At most one command is issued in any cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr, cmd.start, cmd.scan, cmd.pick, cmd.resp}))
    else $error("more than one datapath command at once");

  // A request is never taken in the cycle after one was taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second request taken while one is in flight");

  // Loading the result register raises the result beat.
  a_resp_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp |=> out_ch.valid)
    else $error("result loaded but not presented");

  // A find result never carries a test or range flag.
  a_find_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.found) |-> (!out_ch.is_free && !out_ch.out_of_range))
    else $error("find result carries another flag");

endmodule

// ----- design/bba_ctrl.sv -----
module bba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output bba_pkg::cmd_t cmd,
  input  bba_pkg::sts_t sts
);
  import bba_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_LOOK  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_PICK  = 6'b010000,
    ST_RESP  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The result register can take a new beat when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (sts.is_find && !sts.map_empty) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_nxt = ST_PICK;
        end else if (sts.last_row) begin
          state_nxt = ST_RESP;
        end
      end
      ST_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (slot_free) begin
          cmd.resp  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Result valid flag: set on load, cleared when the beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.resp) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/bba_dp.sv -----
module bba_dp #(
  parameter int MAP_BYTES    = bba_pkg::MAP_BYTES_DEF,
  parameter int SECTOR_BYTES = bba_pkg::SECTOR_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bba_pkg::cmd_t               cmd,
  output bba_pkg::sts_t               sts,
  input  logic [bba_pkg::ACT_W-1:0]   in_action,
  input  logic [bba_pkg::BLOCK_W-1:0] in_block,
  input  logic                        cfg_we,
  input  logic [bba_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                        out_is_free,
  output logic [bba_pkg::BLOCK_W-1:0] out_free_block,
  output logic                        out_found,
  output logic                        out_out_of_range
);
  import bba_pkg::*;

  // Only the first 32768 blocks are addressable, so storage is clamped.
  localparam int MEM_BYTES = (MAP_BYTES < MAX_MAP_BYTES) ? MAP_BYTES : MAX_MAP_BYTES;
  localparam int DEPTH     = (MEM_BYTES + ROW_BYTES - 1) / ROW_BYTES;
  localparam int ROW_W     = $clog2(DEPTH);
  localparam int LIM_W     = $clog2(MEM_BYTES + 1);
  localparam int PW0       = CFG_W + $clog2(SECTOR_BYTES + 1);
  localparam int PROD_W    = (PW0 > LIM_W) ? PW0 : LIM_W;
  localparam int RST_PROD  = CFG_RESET * SECTOR_BYTES;
  localparam int RST_LIMIT = (RST_PROD < MEM_BYTES) ? RST_PROD : MEM_BYTES;
  localparam int RST_LAST  = (RST_LIMIT - 1) / ROW_BYTES;
  localparam int CMP_W     = BYTE_ADDR_W + 1;

  logic [ROW_BITS-1:0] mem [DEPTH];
  logic [ROW_BITS-1:0] rd_data_r;

  logic                 rd_en, wr_en;
  logic [ROW_W-1:0]     rd_addr, wr_addr;
  logic [ROW_BITS-1:0]  wr_data;

  logic [LIM_W-1:0]     limit_r, limit_nxt, lim_m1;
  logic [ROW_W-1:0]     last_row_r, last_row_nxt;
  logic [PROD_W-1:0]    prod;

  act_t                 action_r;
  logic [BLOCK_W-1:0]   blk_r;
  logic                 oor_r, found_r;
  logic [BLOCK_W-1:0]   free_block_r;
  logic [ROW_W-1:0]     row_r;
  logic [7:0]           hit_byte_r;
  logic [BYTE_ADDR_W-1:0] hit_addr_r;

  logic                 in_oor;
  logic [15:0]          nf;
  logic [3:0]           hit_idx;
  logic [7:0]           hit_byte;
  logic [2:0]           zero_bit;
  logic                 rmw;
  logic [ROW_BITS-1:0]  upd_row;

  // Valid map size in bytes from the sector count, clamped to storage.
  assign prod         = PROD_W'(cfg_wdata) * PROD_W'(SECTOR_BYTES);
  assign limit_nxt    = (prod > PROD_W'(MEM_BYTES)) ? LIM_W'(MEM_BYTES) : LIM_W'(prod);
  assign lim_m1       = limit_nxt - LIM_W'(1);
  assign last_row_nxt = lim_m1[ROW_SHIFT +: ROW_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= LIM_W'(RST_LIMIT);
      last_row_r <= ROW_W'(RST_LAST);
    end else if (cfg_we) begin
      limit_r    <= limit_nxt;
      last_row_r <= last_row_nxt;
    end
  end

  // A block is in range when its byte lies below the valid map size.
  assign in_oor = (CMP_W'(in_block[BLOCK_W-1:3]) >= CMP_W'(limit_r));

  // Per-byte search of the current row for a byte with a free bit.
  always_comb begin
    for (int k = 0; k < ROW_BYTES; k++) begin
      nf[k] = (rd_data_r[8*k +: 8] != FULL_BYTE) &&
              (LIM_W'({row_r, 4'(k)}) < limit_r);
    end
    hit_idx = '0;
    for (int k = ROW_BYTES - 1; k >= 0; k--) begin
      if (nf[k]) begin
        hit_idx = 4'(k);
      end
    end
    hit_byte = rd_data_r[8*hit_idx +: 8];
  end

  // Lowest clear bit of the chosen byte.
  always_comb begin
    zero_bit = '0;
    for (int j = 7; j >= 0; j--) begin
      if (!hit_byte_r[j]) begin
        zero_bit = 3'(j);
      end
    end
  end

  // Read-modify-write of the addressed row for assign and release.
  assign rmw = (action_r == ACT_ASSIGN) || (action_r == ACT_RELEASE);
  always_comb begin
    upd_row = rd_data_r;
    upd_row[blk_r[BIT_W-1:0]] = (action_r == ACT_ASSIGN);
  end

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = row_r + ROW_W'(1);
    wr_en   = 1'b0;
    wr_addr = blk_r[BIT_W +: ROW_W];
    wr_data = upd_row;
    if (cmd.clr) begin
      wr_en   = 1'b1;
      wr_addr = row_r;
      wr_data = '0;
    end else if (cmd.start) begin
      rd_en   = 1'b1;
      rd_addr = (act_t'(in_action) == ACT_FIND) ? '0 : in_block[BIT_W +: ROW_W];
    end else if (cmd.scan) begin
      rd_en = !(|nf) && (row_r != last_row_r);
    end else if (cmd.resp) begin
      wr_en = rmw && !oor_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Row counter serves the clearing pass and the scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (cmd.clr) begin
      row_r <= row_r + ROW_W'(1);
    end else if (cmd.start) begin
      row_r <= '0;
    end else if (cmd.scan && rd_en) begin
      row_r <= row_r + ROW_W'(1);
    end
  end

  // Request and search registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      action_r     <= act_t'(in_action);
      blk_r        <= in_block;
      oor_r        <= (act_t'(in_action) != ACT_FIND) && in_oor;
      found_r      <= 1'b0;
      free_block_r <= '0;
    end
    if (cmd.scan && (|nf)) begin
      hit_byte_r <= hit_byte;
      hit_addr_r <= BYTE_ADDR_W'({row_r, hit_idx});
    end
    if (cmd.pick) begin
      found_r      <= 1'b1;
      free_block_r <= {hit_addr_r, zero_bit};
    end
  end

  // Result register, loaded when the controller hands over a beat.
  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_is_free      <= (action_r == ACT_TEST) && !oor_r && !rd_data_r[blk_r[BIT_W-1:0]];
      out_free_block   <= free_block_r;
      out_found        <= found_r;
      out_out_of_range <= oor_r;
    end
  end

  assign sts.clr_done  = (row_r == ROW_W'(DEPTH - 1));
  assign sts.is_find   = (action_r == ACT_FIND);
  assign sts.map_empty = (limit_r == '0);
  assign sts.hit       = |nf;
  assign sts.last_row  = (row_r == last_row_r);

endmodule
